>>> rtl/eulc_pkg.sv
package eulc_pkg;

	// Vertex field width on both channels
	localparam int VERT_W = 6;

	// Result kinds carried on m_tuser
	localparam logic [1:0] ST_EDGE = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	// Packed stream widths
	localparam int S_DATA_W = 16;
	localparam int M_DATA_W = 16;
	localparam int M_USER_W = 2;

endpackage

>>> rtl/euler_circuit_finder.sv
// Channel  | Dir | Fields (tdata low bit up)            | Other
// s_*      | in  | end_a[5:0], end_b[11:6], zero pad    | tlast = last_edge
// m_*      | out | from_vertex[5:0], to_vertex[11:6]    | tuser = status, tlast = last_of_run
//
// Each edge word is a read-modify-write of both halves of the symmetric entry (one entry
// for a self-loop) in the adjacency memory, which has one read port and one write port.
// The solve scans the adjacency row of the current vertex one entry at a time: a walk step
// follows the first nonzero entry, and a backtrack pops the stack and records a circuit word.
// After reset and after every graph a clearing pass over all NUM_VERTICES*NUM_VERTICES entries
// zeroes the adjacency memory; s_tready stays low during it and during the solve.
// A stalled m_tready holds the result word and the whole block.
module euler_circuit_finder #(
	parameter int NUM_VERTICES = 50,
	parameter int MAX_EDGES    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [eulc_pkg::S_DATA_W-1:0] s_tdata,  // end_a, end_b
	input  logic                          s_tlast,  // last_edge
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [eulc_pkg::M_DATA_W-1:0] m_tdata,  // from_vertex, to_vertex
	output logic [eulc_pkg::M_USER_W-1:0] m_tuser,  // status
	output logic                          m_tlast   // last_of_run
);
	import eulc_pkg::*;

	localparam int VW  = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int AW  = $clog2(NUM_VERTICES * NUM_VERTICES);
	localparam int MW  = $clog2(2 * MAX_EDGES + 1);
	localparam int CW  = $clog2(MAX_EDGES + 1);
	localparam int SPW = $clog2(MAX_EDGES + 2);
	localparam int SW  = $clog2(MAX_EDGES + 1);
	localparam int BW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int MDEPTH = NUM_VERTICES * NUM_VERTICES;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_LD_A, S_LD_B, S_LD_C, S_LD_END, S_SOLVE,
		S_SC_RD, S_SC_CHK, S_SC_DEC, S_POP_RD, S_POP_WR, S_CHECK,
		S_EM_RD, S_EM_SHOW, S_EM_WAIT, S_RES_WAIT
	} state_t;

	state_t                  state_q;
	logic [VERT_W-1:0]       a_q, b_q, u_q;
	logic [VW:0]             w_q;
	logic                    last_q, ovf_q;
	logic [CW-1:0]           loaded_q, walked_q, nbuf_q;
	logic [SPW-1:0]          sp_q;
	logic [BW-1:0]           idx_q;
	logic [AW-1:0]           clr_q;
	logic [NUM_VERTICES-1:0] par_q, nz_q;
	logic                    m_tvalid_q, m_tlast_q;
	logic [M_DATA_W-1:0]     m_tdata_q;
	logic [1:0]              m_tuser_q;

	// Adjacency memory
	logic [MW-1:0] mem [MDEPTH];
	logic [MW-1:0] mem_rd_q, mem_wd;
	logic [AW-1:0] mem_ra, mem_wa;
	logic          mem_we;

	// Walk stack and circuit buffer
	logic [VERT_W-1:0]   stk [MAX_EDGES+1];
	logic [VERT_W-1:0]   stk_rd_q, stk_wd;
	logic [SW-1:0]       stk_wa, stk_ra;
	logic                stk_we;
	logic [2*VERT_W-1:0] buf_mem [MAX_EDGES];
	logic [2*VERT_W-1:0] buf_rd_q;
	logic                buf_we;

	logic              a_ok, b_ok, self_ld, self_wk, odd, ok;
	logic [VERT_W-1:0] start;
	logic [VERT_W-1:0] a_m1, b_m1;

	function automatic logic [AW-1:0] addr_f(input logic [VW:0] r, input logic [VW:0] c);
		addr_f = AW'((32'(r) - 1) * NUM_VERTICES + (32'(c) - 1));
	endfunction

	assign a_ok    = (a_q != '0) && (32'(a_q) <= NUM_VERTICES);
	assign b_ok    = (b_q != '0) && (32'(b_q) <= NUM_VERTICES);
	assign self_ld = (a_q == b_q);
	assign self_wk = ((VW+1)'(u_q) == w_q);
	assign a_m1    = a_q - 1'b1;
	assign b_m1    = b_q - 1'b1;
	assign odd     = |par_q;
	assign ok      = (walked_q == loaded_q) && (nbuf_q == walked_q) && (nbuf_q != '0);

	// Pick the highest vertex with edges
	always_comb begin
		start = '0;
		for (int i = 0; i < NUM_VERTICES; i++)
			if (nz_q[i]) start = VERT_W'(i + 1);
	end

	// Drive memory ports from the sequencer state
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_f((VW+1)'(a_q), (VW+1)'(b_q));
		mem_wd = '0;
		mem_ra = addr_f((VW+1)'(a_q), (VW+1)'(b_q));
		stk_we = 1'b0;
		stk_wa = SW'(sp_q);
		stk_wd = 6'(w_q);
		buf_we = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
			end
			S_LD_B: begin
				mem_we = 1'b1;
				mem_wd = MW'(mem_rd_q + (self_ld ? 2 : 1));
				mem_ra = addr_f((VW+1)'(b_q), (VW+1)'(a_q));
			end
			S_LD_C: begin
				mem_we = 1'b1;
				mem_wa = addr_f((VW+1)'(b_q), (VW+1)'(a_q));
				mem_wd = MW'(mem_rd_q + 1'b1);
			end
			S_SOLVE: begin
				stk_we = (!ovf_q && !odd && nz_q != '0);
				stk_wa = '0;
				stk_wd = start;
			end
			S_SC_RD: mem_ra = addr_f((VW+1)'(u_q), w_q);
			S_SC_CHK: begin
				mem_we = (mem_rd_q != '0);
				mem_wa = addr_f((VW+1)'(u_q), w_q);
				mem_wd = MW'(mem_rd_q - (self_wk ? 2 : 1));
				mem_ra = addr_f(w_q, (VW+1)'(u_q));
				stk_we = (mem_rd_q != '0) && self_wk;
			end
			S_SC_DEC: begin
				mem_we = 1'b1;
				mem_wa = addr_f(w_q, (VW+1)'(u_q));
				mem_wd = MW'(mem_rd_q - 1'b1);
				stk_we = 1'b1;
			end
			S_POP_WR: buf_we = (32'(nbuf_q) < MAX_EDGES);
			default: ;
		endcase
	end

	assign stk_ra = SW'(sp_q - 2'd2);

	// Adjacency memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		mem_rd_q <= mem[mem_ra];
	end

	// Stack memory
	always_ff @(posedge clk) begin
		if (stk_we) stk[stk_wa] <= stk_wd;
		stk_rd_q <= stk[stk_ra];
	end

	// Circuit buffer, written in post-order and read back in reverse
	always_ff @(posedge clk) begin
		if (buf_we) buf_mem[nbuf_q[BW-1:0]] <= {stk_rd_q, u_q};
		buf_rd_q <= buf_mem[idx_q];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			loaded_q   <= '0;
			walked_q   <= '0;
			nbuf_q     <= '0;
			sp_q       <= '0;
			ovf_q      <= 1'b0;
			par_q      <= '0;
			nz_q       <= '0;
			m_tvalid_q <= 1'b0;
			m_tlast_q  <= 1'b0;
			m_tuser_q  <= ST_EDGE;
			m_tdata_q  <= '0;
			idx_q      <= '0;
			last_q     <= 1'b0;
			a_q        <= '0;
			b_q        <= '0;
			u_q        <= '0;
			w_q        <= '0;
		end else begin
			unique case (state_q)
				// Zero the adjacency memory and the edge, walk, buffer, parity and degree state
				S_CLEAR: begin
					loaded_q <= '0;
					walked_q <= '0;
					nbuf_q   <= '0;
					ovf_q    <= 1'b0;
					par_q    <= '0;
					nz_q     <= '0;
					clr_q    <= clr_q + 1'b1;
					if (32'(clr_q) == MDEPTH - 1) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						a_q     <= s_tdata[VERT_W-1:0];
						b_q     <= s_tdata[2*VERT_W-1:VERT_W];
						last_q  <= s_tlast;
						state_q <= S_LD_A;
					end
				end
				// Count the edge, drop it on overflow or on an out-of-range vertex
				S_LD_A: begin
					if (32'(loaded_q) >= MAX_EDGES) begin
						ovf_q   <= 1'b1;
						state_q <= S_LD_END;
					end else begin
						loaded_q <= loaded_q + 1'b1;
						state_q  <= (a_ok && b_ok) ? S_LD_B : S_LD_END;
					end
				end
				S_LD_B: begin
					if (!self_ld) begin
						par_q[a_m1[VW-1:0]] <= ~par_q[a_m1[VW-1:0]];
						par_q[b_m1[VW-1:0]] <= ~par_q[b_m1[VW-1:0]];
					end
					nz_q[a_m1[VW-1:0]] <= 1'b1;
					nz_q[b_m1[VW-1:0]] <= 1'b1;
					state_q <= self_ld ? S_LD_END : S_LD_C;
				end
				S_LD_C: state_q <= S_LD_END;
				S_LD_END: state_q <= last_q ? S_SOLVE : S_IDLE;
				S_SOLVE: begin
					if (ovf_q) begin
						m_tuser_q <= ST_OVF;
						m_tdata_q <= '0;
						m_tlast_q <= 1'b1;
						m_tvalid_q <= 1'b1;
						state_q   <= S_RES_WAIT;
					end else if (odd || nz_q == '0) begin
						m_tuser_q <= ST_FAIL;
						m_tdata_q <= '0;
						m_tlast_q <= 1'b1;
						m_tvalid_q <= 1'b1;
						state_q   <= S_RES_WAIT;
					end else begin
						u_q     <= start;
						sp_q    <= SPW'(1);
						w_q     <= (VW+1)'(1);
						state_q <= S_SC_RD;
					end
				end
				// Read the next candidate neighbor, or backtrack on a full stack
				S_SC_RD: state_q <= (32'(sp_q) > MAX_EDGES) ? S_POP_RD : S_SC_CHK;
				S_SC_CHK: begin
					if (mem_rd_q != '0) begin
						if (self_wk) begin
							sp_q     <= sp_q + 1'b1;
							walked_q <= walked_q + 1'b1;
							w_q      <= (VW+1)'(1);
							state_q  <= S_SC_RD;
						end else begin
							state_q <= S_SC_DEC;
						end
					end else if (32'(w_q) == NUM_VERTICES) begin
						state_q <= S_POP_RD;
					end else begin
						w_q     <= w_q + 1'b1;
						state_q <= S_SC_RD;
					end
				end
				// Push the neighbor and move there
				S_SC_DEC: begin
					sp_q     <= sp_q + 1'b1;
					walked_q <= walked_q + 1'b1;
					u_q      <= VERT_W'(w_q);
					w_q      <= (VW+1)'(1);
					state_q  <= S_SC_RD;
				end
				S_POP_RD: begin
					sp_q    <= sp_q - 1'b1;
					state_q <= (sp_q == SPW'(1)) ? S_CHECK : S_POP_WR;
				end
				// Record the edge back to the new top
				S_POP_WR: begin
					if (32'(nbuf_q) < MAX_EDGES) nbuf_q <= nbuf_q + 1'b1;
					u_q     <= stk_rd_q;
					w_q     <= (VW+1)'(1);
					state_q <= S_SC_RD;
				end
				S_CHECK: begin
					if (ok) begin
						idx_q   <= BW'(nbuf_q - 1'b1);
						state_q <= S_EM_RD;
					end else begin
						m_tuser_q <= ST_FAIL;
						m_tdata_q <= '0;
						m_tlast_q <= 1'b1;
						m_tvalid_q <= 1'b1;
						state_q   <= S_RES_WAIT;
					end
				end
				S_EM_RD: state_q <= S_EM_SHOW;
				S_EM_SHOW: begin
					m_tdata_q  <= {4'b0, buf_rd_q[VERT_W-1:0], buf_rd_q[2*VERT_W-1:VERT_W]};
					m_tuser_q  <= ST_EDGE;
					m_tlast_q  <= (idx_q == '0);
					m_tvalid_q <= 1'b1;
					state_q    <= S_EM_WAIT;
				end
				S_EM_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						if (idx_q == '0) begin
							state_q <= S_CLEAR;
						end else begin
							idx_q   <= idx_q - 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				S_RES_WAIT: begin
					if (m_tready) begin
						m_tvalid_q <= 1'b0;
						state_q    <= S_CLEAR;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule

>>> rtl/eulc_check.sv
module eulc_check (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [eulc_pkg::S_DATA_W-1:0] s_tdata,
	input logic                          s_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [eulc_pkg::M_DATA_W-1:0] m_tdata,
	input logic [eulc_pkg::M_USER_W-1:0] m_tuser,
	input logic                          m_tlast
);
	import eulc_pkg::*;

	// No edge word is taken while a result word is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("input accepted during output");

	// Failure and overflow words carry no vertices and close the run
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_EDGE) |-> (m_tdata == '0 && m_tlast))
		else $error("bad status word");

	// Circuit edges name nonzero vertices
	a_edge_word: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_EDGE) |-> (m_tdata[5:0] != '0 && m_tdata[11:6] != '0))
		else $error("zero vertex in circuit word");

	// A stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("output changed under stall");

endmodule

bind euler_circuit_finder eulc_check u_eulc_check (.*);
